FILE: hdl/vna_pkg.sv
// ---------------------------------------------------------------------------
// vna_pkg
// Command and status codes shared by the vertex normal averager and its checker.
// ---------------------------------------------------------------------------
`default_nettype none

package vna_pkg;

	localparam logic [1:0] CMD_POS  = 2'd0;
	localparam logic [1:0] CMD_TRI  = 2'd1;
	localparam logic [1:0] CMD_EMIT = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FLAT   = 2'd1;
	localparam logic [1:0] ST_NOFACE = 2'd2;

	localparam logic signed [15:0] NRM_ONE  = 16'sd16384;
	localparam logic signed [15:0] NRM_MONE = -16'sd16384;

endpackage

`default_nettype wire

FILE: hdl/vertex_normal_averager.sv
// ---------------------------------------------------------------------------
// vertex_normal_averager
// Smooth per-vertex normals: position writes, triangle accumulation of
// Q1.14 unit face normals, and emission of rounded per-vertex averages.
// ---------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  in      | in_valid/in_ready  | command, vertex_index, pos_*, corner_*
//  out     | out_valid/out_ready| normal_x/y/z, face_count, status
//
//  One item at a time. Emit time is set by the 15-step shared divider, run
//  once per axis. Triangle time is set by the one-bit-per-cycle normalize
//  shift, the 31-step square root and the divider; a zero-area triangle
//  skips all three. After reset a clearing pass over all MAX_VERTICES
//  entries zeroes sums and counts; in_ready stays low meanwhile. A result
//  waiting on out_ready holds the next item only at its final transfer.
// ---------------------------------------------------------------------------
`default_nettype none

module vertex_normal_averager #(
	parameter int MAX_VERTICES         = 1024,
	parameter int MAX_FACES_PER_VERTEX = 255
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         command,
	input  wire logic [9:0]         vertex_index,
	input  wire logic signed [15:0] pos_x,
	input  wire logic signed [15:0] pos_y,
	input  wire logic signed [15:0] pos_z,
	input  wire logic [9:0]         corner_first,
	input  wire logic [9:0]         corner_second,
	input  wire logic [9:0]         corner_third,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      normal_x,
	output logic signed [15:0]      normal_y,
	output logic signed [15:0]      normal_z,
	output logic [7:0]              face_count,
	output logic [1:0]              status
);

	localparam int IW  = $clog2(MAX_VERTICES);
	localparam int CW  = $clog2(MAX_FACES_PER_VERTEX + 1);
	localparam int SW  = CW + 15;
	localparam int DNW = (SW + 1 > 45) ? SW + 1 : 45;
	localparam int DDW = (CW + 1 > 31) ? CW + 1 : 31;

	localparam logic [4:0] S_CLR    = 5'd0;
	localparam logic [4:0] S_IDLE   = 5'd1;
	localparam logic [4:0] S_PRD    = 5'd2;
	localparam logic [4:0] S_PCAP   = 5'd3;
	localparam logic [4:0] S_EDGE   = 5'd4;
	localparam logic [4:0] S_MUL    = 5'd5;
	localparam logic [4:0] S_CROSS  = 5'd6;
	localparam logic [4:0] S_NORM   = 5'd7;
	localparam logic [4:0] S_SQ     = 5'd8;
	localparam logic [4:0] S_SSUM   = 5'd9;
	localparam logic [4:0] S_SQRT   = 5'd10;
	localparam logic [4:0] S_DVLD   = 5'd11;
	localparam logic [4:0] S_DVRUN  = 5'd12;
	localparam logic [4:0] S_DVEND  = 5'd13;
	localparam logic [4:0] S_ACCRD  = 5'd14;
	localparam logic [4:0] S_ACCWR  = 5'd15;
	localparam logic [4:0] S_EMRD   = 5'd16;
	localparam logic [4:0] S_EMCHK  = 5'd17;
	localparam logic [4:0] S_FIN    = 5'd18;

	function automatic logic [IW-1:0] vmod(input logic [9:0] v);
		logic [31:0] r;
		r = 32'(v);
		for (int j = 9; j >= 0; j--) begin
			if (r >= (32'(MAX_VERTICES) << j)) begin
				r = r - (32'(MAX_VERTICES) << j);
			end
		end
		return r[IW-1:0];
	endfunction

	// memories
	logic [47:0]     pos_mem [MAX_VERTICES];
	logic [3*SW-1:0] sum_mem [MAX_VERTICES];
	logic [CW-1:0]   cnt_mem [MAX_VERTICES];

	logic [47:0]     pos_rd_q;
	logic [3*SW-1:0] sum_rd_q;
	logic [CW-1:0]   cnt_rd_q;

	logic            pos_we;
	logic [IW-1:0]   pos_waddr;
	logic [IW-1:0]   pos_raddr;
	logic            acc_we;
	logic [IW-1:0]   acc_waddr;
	logic [IW-1:0]   acc_raddr;
	logic [3*SW-1:0] sum_wdata;
	logic [CW-1:0]   cnt_wdata;

	// control and datapath registers
	logic [4:0]               state_q;
	logic [1:0]               k_q;
	logic                     op_tri_q;
	logic                     flat_q;
	logic [IW-1:0]            clr_q;
	logic [IW-1:0]            vidx_q;
	logic [IW-1:0]            cor_q [3];
	logic [47:0]              p_q [3];
	logic signed [16:0]       e1_q [3];
	logic signed [16:0]       e2_q [3];
	logic signed [33:0]       prod_q [6];
	logic [2:0]               neg_q;
	logic [33:0]              mag_q [3];
	logic [59:0]              sq_q [3];
	logic [61:0]              s_q;
	logic [30:0]              root_q;
	logic [32:0]              rem_q;
	logic [4:0]               it_q;
	logic [DDW-1:0]           dv_r_q;
	logic [DDW-1:0]           dv_d_q;
	logic [14:0]              dv_lo_q;
	logic [14:0]              dv_qt_q;
	logic                     dv_neg_q;
	logic [2:0]               sm_neg_q;
	logic [SW-1:0]            sm_mag_q [3];
	logic [CW-1:0]            cnt_q;
	logic signed [15:0]       n_q [3];
	logic [7:0]               res_cnt_q;
	logic [1:0]               res_st_q;
	logic                     out_valid_q;
	logic signed [15:0]       nx_q;
	logic signed [15:0]       ny_q;
	logic signed [15:0]       nz_q;
	logic [7:0]               fc_q;
	logic [1:0]               st_q;

	// combinational helpers
	logic [IW-1:0]            in_vidx;
	logic                     in_fire;
	logic signed [34:0]       cr [3];
	logic [33:0]              cmag [3];
	logic [33:0]              mx;
	logic [34:0]              sqt;
	logic [34:0]              sqtrial;
	logic [DDW:0]             dvt;
	logic                     dvge;
	logic [DNW-1:0]           dv_num;
	logic [DDW-1:0]           dv_den;
	logic [14:0]              qclip;
	logic signed [SW-1:0]     sc [3];

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid & in_ready;
	assign in_vidx  = vmod(vertex_index);

	always_ff @(posedge clk) begin
		if (pos_we) begin
			pos_mem[pos_waddr] <= {pos_z, pos_y, pos_x};
		end
		if (acc_we) begin
			sum_mem[acc_waddr] <= sum_wdata;
			cnt_mem[acc_waddr] <= cnt_wdata;
		end
		pos_rd_q <= pos_mem[pos_raddr];
		sum_rd_q <= sum_mem[acc_raddr];
		cnt_rd_q <= cnt_mem[acc_raddr];
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cr[i]   = 35'(prod_q[2*i]) - 35'(prod_q[2*i+1]);
			cmag[i] = cr[i][34] ? 34'(-cr[i]) : 34'(cr[i]);
			sc[i]   = sum_rd_q[i*SW +: SW];
		end
		mx = mag_q[0];
		if (mag_q[1] > mx) begin
			mx = mag_q[1];
		end
		if (mag_q[2] > mx) begin
			mx = mag_q[2];
		end
		sqt     = {rem_q[32:0], s_q[61:60]};
		sqtrial = {2'b00, root_q, 2'b01};
		dvt     = {dv_r_q, dv_lo_q[14]};
		dvge    = (dvt >= {1'b0, dv_d_q});
		qclip   = (dv_qt_q > 15'd16384) ? 15'd16384 : dv_qt_q;
		if (op_tri_q) begin
			dv_num = DNW'({mag_q[k_q][29:0], 14'b0}) + DNW'(root_q >> 1);
			dv_den = DDW'(root_q);
		end else begin
			dv_num = DNW'({sm_mag_q[k_q], 1'b0}) + DNW'(cnt_q);
			dv_den = DDW'({cnt_q, 1'b0});
		end
	end

	// memory port control
	always_comb begin
		pos_we    = 1'b0;
		pos_waddr = in_vidx;
		pos_raddr = cor_q[k_q];
		acc_we    = 1'b0;
		acc_waddr = cor_q[k_q];
		acc_raddr = (state_q == S_EMRD) ? vidx_q : cor_q[k_q];
		sum_wdata = '0;
		cnt_wdata = '0;
		unique case (state_q)
			S_CLR: begin
				acc_we    = 1'b1;
				acc_waddr = clr_q;
			end
			S_IDLE: begin
				if (in_fire && command == vna_pkg::CMD_POS) begin
					pos_we    = 1'b1;
					acc_we    = 1'b1;
					acc_waddr = in_vidx;
				end
			end
			S_ACCWR: begin
				if (cnt_rd_q < CW'(MAX_FACES_PER_VERTEX)) begin
					acc_we    = 1'b1;
					cnt_wdata = CW'(cnt_rd_q + 1'b1);
					for (int j = 0; j < 3; j++) begin
						sum_wdata[j*SW +: SW] = flat_q ? sc[j] : sc[j] + SW'(n_q[j]);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					if (clr_q == IW'(MAX_VERTICES - 1)) begin
						state_q <= S_IDLE;
					end
					clr_q <= clr_q + 1'b1;
				end
				S_IDLE: begin
					if (in_fire) begin
						k_q       <= '0;
						vidx_q    <= in_vidx;
						cor_q[0]  <= vmod(corner_first);
						cor_q[1]  <= vmod(corner_second);
						cor_q[2]  <= vmod(corner_third);
						res_cnt_q <= '0;
						res_st_q  <= vna_pkg::ST_OK;
						for (int i = 0; i < 3; i++) begin
							n_q[i] <= '0;
						end
						priority case (command)
							vna_pkg::CMD_TRI: begin
								op_tri_q <= 1'b1;
								flat_q   <= 1'b0;
								state_q  <= S_PRD;
							end
							vna_pkg::CMD_EMIT: begin
								op_tri_q <= 1'b0;
								state_q  <= S_EMRD;
							end
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_PRD: begin
					if (k_q != 2'd0) begin
						p_q[k_q - 2'd1] <= pos_rd_q;
					end
					if (k_q == 2'd2) begin
						state_q <= S_PCAP;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				S_PCAP: begin
					p_q[2]  <= pos_rd_q;
					state_q <= S_EDGE;
				end
				S_EDGE: begin
					for (int i = 0; i < 3; i++) begin
						e1_q[i] <= 17'(signed'(p_q[1][i*16 +: 16]))
							- 17'(signed'(p_q[0][i*16 +: 16]));
						e2_q[i] <= 17'(signed'(p_q[2][i*16 +: 16]))
							- 17'(signed'(p_q[0][i*16 +: 16]));
					end
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q[0] <= e1_q[1] * e2_q[2];
					prod_q[1] <= e1_q[2] * e2_q[1];
					prod_q[2] <= e1_q[2] * e2_q[0];
					prod_q[3] <= e1_q[0] * e2_q[2];
					prod_q[4] <= e1_q[0] * e2_q[1];
					prod_q[5] <= e1_q[1] * e2_q[0];
					state_q   <= S_CROSS;
				end
				S_CROSS: begin
					for (int i = 0; i < 3; i++) begin
						neg_q[i] <= cr[i][34];
						mag_q[i] <= cmag[i];
					end
					state_q <= S_NORM;
				end
				S_NORM: begin
					priority if (mx == '0) begin
						flat_q   <= 1'b1;
						res_st_q <= vna_pkg::ST_FLAT;
						k_q      <= '0;
						state_q  <= S_ACCRD;
					end else if (mx[33:30] != 4'd0) begin
						for (int i = 0; i < 3; i++) begin
							mag_q[i] <= mag_q[i] >> 1;
						end
					end else if (!mx[29]) begin
						for (int i = 0; i < 3; i++) begin
							mag_q[i] <= mag_q[i] << 1;
						end
					end else begin
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					for (int i = 0; i < 3; i++) begin
						sq_q[i] <= mag_q[i][29:0] * mag_q[i][29:0];
					end
					state_q <= S_SSUM;
				end
				S_SSUM: begin
					s_q     <= 62'(sq_q[0]) + 62'(sq_q[1]) + 62'(sq_q[2]);
					rem_q   <= '0;
					root_q  <= '0;
					it_q    <= 5'd30;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					if (sqt >= sqtrial) begin
						rem_q  <= 33'(sqt - sqtrial);
						root_q <= {root_q[29:0], 1'b1};
					end else begin
						rem_q  <= sqt[32:0];
						root_q <= {root_q[29:0], 1'b0};
					end
					s_q  <= s_q << 2;
					it_q <= it_q - 5'd1;
					if (it_q == 5'd0) begin
						k_q     <= '0;
						state_q <= S_DVLD;
					end
				end
				S_DVLD: begin
					dv_r_q   <= DDW'(dv_num >> 15);
					dv_lo_q  <= dv_num[14:0];
					dv_d_q   <= dv_den;
					dv_qt_q  <= '0;
					dv_neg_q <= op_tri_q ? neg_q[k_q] : sm_neg_q[k_q];
					it_q     <= 5'd15;
					state_q  <= S_DVRUN;
				end
				S_DVRUN: begin
					dv_r_q  <= dvge ? DDW'(dvt - {1'b0, dv_d_q}) : dvt[DDW-1:0];
					dv_lo_q <= dv_lo_q << 1;
					dv_qt_q <= {dv_qt_q[13:0], dvge};
					it_q    <= it_q - 5'd1;
					if (it_q == 5'd1) begin
						state_q <= S_DVEND;
					end
				end
				S_DVEND: begin
					n_q[k_q] <= dv_neg_q ? -signed'(16'(qclip)) : signed'(16'(qclip));
					if (k_q == 2'd2) begin
						k_q <= '0;
						if (op_tri_q) begin
							state_q <= S_ACCRD;
						end else begin
							res_cnt_q <= 8'(cnt_q);
							state_q   <= S_FIN;
						end
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= S_DVLD;
					end
				end
				S_ACCRD: begin
					state_q <= S_ACCWR;
				end
				S_ACCWR: begin
					if (k_q == 2'd2) begin
						state_q <= S_FIN;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= S_ACCRD;
					end
				end
				S_EMRD: begin
					state_q <= S_EMCHK;
				end
				S_EMCHK: begin
					for (int i = 0; i < 3; i++) begin
						sm_neg_q[i] <= sc[i][SW-1];
						sm_mag_q[i] <= sc[i][SW-1] ? SW'(-sc[i]) : SW'(sc[i]);
					end
					cnt_q <= cnt_rd_q;
					k_q   <= '0;
					if (cnt_rd_q == '0) begin
						res_st_q <= vna_pkg::ST_NOFACE;
						state_q  <= S_FIN;
					end else begin
						state_q <= S_DVLD;
					end
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						nx_q        <= n_q[0];
						ny_q        <= n_q[1];
						nz_q        <= n_q[2];
						fc_q        <= res_cnt_q;
						st_q        <= res_st_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign normal_x   = nx_q;
	assign normal_y   = ny_q;
	assign normal_z   = nz_q;
	assign face_count = fc_q;
	assign status     = st_q;

endmodule

`default_nettype wire

FILE: hdl/vna_checker.sv
// ---------------------------------------------------------------------------
// vna_checker
// Port-level checks for the vertex normal averager, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module vna_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic signed [15:0] normal_x,
	input wire logic signed [15:0] normal_y,
	input wire logic signed [15:0] normal_z,
	input wire logic [7:0]         face_count,
	input wire logic [1:0]         status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(normal_x) && $stable(normal_y)
			&& $stable(normal_z) && $stable(face_count) && $stable(status))
		else $error("result changed while stalled");

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted an item while busy");

	a_zero_normal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == vna_pkg::ST_FLAT || status == vna_pkg::ST_NOFACE)
			|-> normal_x == 16'sd0 && normal_y == 16'sd0 && normal_z == 16'sd0
				&& face_count == 8'd0)
		else $error("flagged result carries data");

	a_count_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && face_count != 8'd0 |-> status == vna_pkg::ST_OK)
		else $error("counted vertex with bad status");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> normal_x >= vna_pkg::NRM_MONE && normal_x <= vna_pkg::NRM_ONE
			&& normal_y >= vna_pkg::NRM_MONE && normal_y <= vna_pkg::NRM_ONE
			&& normal_z >= vna_pkg::NRM_MONE && normal_z <= vna_pkg::NRM_ONE)
		else $error("normal out of Q1.14 range");

endmodule

bind vertex_normal_averager vna_checker u_vna_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.normal_x   (normal_x),
	.normal_y   (normal_y),
	.normal_z   (normal_z),
	.face_count (face_count),
	.status     (status)
);

`default_nettype wire

FILE: test/vertex_normal_averager_tb.sv
// ---------------------------------------------------------------------------
// vertex_normal_averager_tb
// Self-checking bench: directed extremes, face count saturation, then random
// position/triangle/emit/unused-command traffic under four idle and stall mixes,
// all scored against an in-bench predictor of the smoothing arithmetic.
// ---------------------------------------------------------------------------
`default_nettype none

module vertex_normal_averager_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam int         NVERT    = 1024;
	localparam int         FACE_MAX = 255;

	typedef struct packed {
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic [7:0]         fc;
		logic [1:0]         st;
	} normal_res_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [1:0] command;
	logic [9:0] vertex_index, corner_first, corner_second, corner_third;
	logic signed [15:0] pos_x, pos_y, pos_z;
	logic signed [15:0] normal_x, normal_y, normal_z;
	logic [7:0] face_count;
	logic [1:0] status;

	vertex_normal_averager dut (.*);

	// predictor state
	logic signed [15:0] vtx_pos[NVERT][3];
	int                 nrm_sum[NVERT][3];
	int                 face_cnt[NVERT];
	bit                 pos_valid[NVERT];
	int                 written_list[$];

	normal_res_t pending_normals[$];
	int errors, n_results, n_flat, n_noface, n_sat;
	int idle_pct, stall_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("Timeout at %0t", $time);
		$display("Mismatches found");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		normal_res_t e, a;
		if (arst_n && out_valid && out_ready) begin
			a = '{normal_x, normal_y, normal_z, face_count, status};
			n_results++;
			if (pending_normals.size() == 0) begin
				errors++;
				$display("%0t unexpected transfer: %p", $time, a);
			end else begin
				e = pending_normals.pop_front();
				if (a.nx !== e.nx || a.ny !== e.ny || a.nz !== e.nz ||
				    a.fc !== e.fc || a.st !== e.st) begin
					errors++;
					$display("%0t mismatch: expected %p actual %p", $time, e, a);
				end
			end
		end
	end

	function automatic longint unsigned isqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic bit unit_normal(int a, int b, int c, output int n[3]);
		longint e1[3], e2[3], cr[3];
		longint unsigned mag[3], mx, s, len, q;
		for (int i = 0; i < 3; i++) begin
			e1[i] = longint'(vtx_pos[b][i]) - longint'(vtx_pos[a][i]);
			e2[i] = longint'(vtx_pos[c][i]) - longint'(vtx_pos[a][i]);
		end
		cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
		cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
		cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = cr[i] < 0 ? -cr[i] : cr[i];
			if (mag[i] > mx) mx = mag[i];
			n[i] = 0;
		end
		if (mx == 0) return 1'b1;
		while (mx >= (64'd1 << 30)) begin
			mx >>= 1;
			for (int i = 0; i < 3; i++) mag[i] >>= 1;
		end
		while (mx < (64'd1 << 29)) begin
			mx <<= 1;
			for (int i = 0; i < 3; i++) mag[i] <<= 1;
		end
		s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
		len = isqrt(s);
		for (int i = 0; i < 3; i++) begin
			q = (mag[i] * 16384 + len / 2) / len;
			if (q > 16384) q = 16384;
			n[i] = cr[i] < 0 ? -int'(q) : int'(q);
		end
		return 1'b0;
	endfunction

	function automatic normal_res_t predict_normal(logic [1:0] cmd, int vi,
			logic signed [15:0] px, py, pz, int c0, c1, c2);
		normal_res_t r;
		int n[3], cor[3], v;
		bit flat;
		longint sm;
		longint unsigned m, q;
		r = '0;
		case (cmd)
			vna_pkg::CMD_POS: begin
				vtx_pos[vi] = '{px, py, pz};
				nrm_sum[vi] = '{0, 0, 0};
				face_cnt[vi] = 0;
				if (!pos_valid[vi]) written_list.push_back(vi);
				pos_valid[vi] = 1'b1;
			end
			vna_pkg::CMD_TRI: begin
				cor = '{c0, c1, c2};
				flat = unit_normal(c0, c1, c2, n);
				for (int k = 0; k < 3; k++) begin
					v = cor[k];
					if (face_cnt[v] >= FACE_MAX) begin
						n_sat++;
						continue;
					end
					face_cnt[v]++;
					if (!flat)
						for (int i = 0; i < 3; i++) nrm_sum[v][i] += n[i];
				end
				r.nx = 16'(n[0]);
				r.ny = 16'(n[1]);
				r.nz = 16'(n[2]);
				r.st = flat ? vna_pkg::ST_FLAT : vna_pkg::ST_OK;
				if (flat) n_flat++;
			end
			vna_pkg::CMD_EMIT: begin
				if (face_cnt[vi] == 0) begin
					r.st = vna_pkg::ST_NOFACE;
					n_noface++;
				end else begin
					for (int i = 0; i < 3; i++) begin
						sm = nrm_sum[vi][i];
						m = sm < 0 ? -sm : sm;
						q = (2 * m + face_cnt[vi]) / (2 * face_cnt[vi]);
						n[i] = sm < 0 ? -int'(q) : int'(q);
					end
					r.nx = 16'(n[0]);
					r.ny = 16'(n[1]);
					r.nz = 16'(n[2]);
					r.fc = 8'(face_cnt[vi]);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_item(logic [1:0] cmd, logic [9:0] vi,
			logic signed [15:0] px, py, pz, logic [9:0] a, b, c);
		normal_res_t e;
		e = predict_normal(cmd, vi, px, py, pz, a, b, c);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		in_valid <= 1'b1;
		command <= cmd;
		vertex_index <= vi;
		pos_x <= px;
		pos_y <= py;
		pos_z <= pz;
		corner_first <= a;
		corner_second <= b;
		corner_third <= c;
		do @(posedge clk); while (!in_ready);
		pending_normals.push_back(e);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_normals.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_pos(int vi, logic signed [15:0] px, py, pz);
		send_item(vna_pkg::CMD_POS, 10'(vi), px, py, pz, '0, '0, '0);
	endtask

	task automatic tri_item(int a, int b, int c);
		send_item(vna_pkg::CMD_TRI, '0, '0, '0, '0, 10'(a), 10'(b), 10'(c));
	endtask

	task automatic emit_item(int vi);
		send_item(vna_pkg::CMD_EMIT, 10'(vi), '0, '0, '0, '0, '0, '0);
	endtask

	function automatic logic signed [15:0] rnd_coord();
		logic signed [15:0] v;
		v = 16'($urandom);
		return v >>> $urandom_range(12);
	endfunction

	task automatic test_directed();
		write_pos(0, 0, 0, 0);
		write_pos(1, 16'sd256, 0, 0);
		write_pos(2, 0, 16'sd256, 0);
		write_pos(3, -16'sd32768, -16'sd32768, -16'sd32768);
		write_pos(4, 16'sd32767, -16'sd32768, 16'sd32767);
		write_pos(5, -16'sd32768, 16'sd32767, 16'sd32767);
		write_pos(1023, 16'sd32767, 16'sd32767, 16'sd32767);
		tri_item(0, 1, 2);
		tri_item(0, 2, 1);
		tri_item(3, 4, 5);
		tri_item(1023, 4, 3);
		tri_item(0, 0, 1);      // repeated corner, zero area
		tri_item(2, 2, 2);
		write_pos(6, 16'sd512, 0, 0);
		tri_item(0, 1, 6);      // collinear
		emit_item(0);
		emit_item(1);
		emit_item(2);
		emit_item(3);
		emit_item(1023);
		emit_item(700);         // never given a face
		send_item(CMD_NONE, 10'h3ff, -16'sd1, -16'sd1, -16'sd1, 10'h3ff, 10'h3ff, 10'h3ff);
		write_pos(0, 0, 0, 0);  // rewrite clears the sum
		emit_item(0);
		drain();
	endtask

	task automatic test_saturation();
		write_pos(10, 0, 0, 16'sd100);
		write_pos(11, 16'sd300, -16'sd20, 0);
		write_pos(12, 16'sd7, 16'sd900, -16'sd50);
		write_pos(13, 16'sd1, 16'sd2, 16'sd3);
		for (int i = 0; i < 260; i++) tri_item(10, 11, 12);
		for (int i = 0; i < 90; i++) tri_item(13, 13, 13);
		emit_item(10);
		emit_item(12);
		emit_item(13);
		write_pos(10, 0, 0, 16'sd100);
		emit_item(10);
		drain();
	endtask

	task automatic test_random(int items, int idle, int stall);
		int r, vi, a, b, c;
		idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < items; i++) begin
			r = $urandom_range(99);
			if (r < 15 || written_list.size() < 3) begin
				vi = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(63);
				write_pos(vi, rnd_coord(), rnd_coord(), rnd_coord());
			end else if (r < 70) begin
				a = written_list[$urandom_range(written_list.size() - 1)];
				b = written_list[$urandom_range(written_list.size() - 1)];
				c = written_list[$urandom_range(written_list.size() - 1)];
				if ($urandom_range(9) == 0) c = a;
				send_item(vna_pkg::CMD_TRI, 10'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 10'(a), 10'(b), 10'(c));
			end else if (r < 95) begin
				vi = ($urandom_range(4) == 0) ? $urandom_range(1023) : $urandom_range(63);
				send_item(vna_pkg::CMD_EMIT, 10'(vi), 16'($urandom), 16'($urandom),
					16'($urandom), 10'($urandom), 10'($urandom), 10'($urandom));
			end else
				send_item(CMD_NONE, 10'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 10'($urandom), 10'($urandom), 10'($urandom));
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = vna_pkg::CMD_POS;
		vertex_index = '0;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		corner_first = '0;
		corner_second = '0;
		corner_third = '0;
		idle_pct = 0;
		stall_pct = 0;
		for (int i = 0; i < NVERT; i++) begin
			nrm_sum[i] = '{0, 0, 0};
			face_cnt[i] = 0;
			pos_valid[i] = 1'b0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_saturation();
		test_random(350, 0, 0);
		test_random(350, 53, 0);
		test_random(350, 0, 53);
		test_random(350, 38, 38);
		$display("Checked %0d transfers: %0d zero-area faces, %0d faceless emits,",
			n_results, n_flat, n_noface);
		$display("%0d saturated corner hits, %0d vertices written", n_sat,
			written_list.size());
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire

FILE: sim.f
hdl/vna_pkg.sv
hdl/vertex_normal_averager.sv
hdl/vna_checker.sv
test/vertex_normal_averager_tb.sv
